// ----- rtl/cpf_pkg.sv -----
package cpf_pkg;

    localparam int MAX_ROWS = 4096;
    localparam int ROW_W    = 12;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int VAL_W    = 64;
    localparam int PADDR_W  = 5;

    typedef enum logic [2:0] {
        OP_LE = 3'd0,
        OP_LT = 3'd1,
        OP_GE = 3'd2,
        OP_GT = 3'd3,
        OP_EQ = 3'd4
    } t_cmp_op;

    typedef enum logic [PADDR_W-1:0] {
        REG_COMPARE_OP  = 5'd0,
        REG_VALUE_KIND  = 5'd8,
        REG_RIGHT_LIT   = 5'd16,
        REG_LITERAL     = 5'd24
    } t_reg_addr;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_order;

    // three-way order of two raw 64-bit values; all zero means unordered
    function automatic t_order order_of(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b,
                                        input logic             is_dbl);
        t_order           o;
        logic             a_nan;
        logic             b_nan;
        logic             both_zero;
        logic             mag_lt;
        logic             mag_eq;
        logic             s_lt;
        o         = '0;
        a_nan     = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
        b_nan     = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
        both_zero = (a[62:0] == '0) && (b[62:0] == '0);
        mag_lt    = a[62:0] < b[62:0];
        mag_eq    = a[62:0] == b[62:0];
        s_lt      = {~a[63], a[62:0]} < {~b[63], b[62:0]};
        if (!is_dbl) begin
            o.eq = (a == b);
            o.lt = s_lt;
            o.gt = !s_lt && (a != b);
        end else if (a_nan || b_nan) begin
            o = '0;
        end else if (both_zero || (a == b)) begin
            o.eq = 1'b1;
        end else if (a[63] != b[63]) begin
            o.lt = a[63];
            o.gt = b[63];
        end else begin
            // same sign: magnitude order, flipped when negative
            o.lt = a[63] ? (!mag_lt && !mag_eq) : mag_lt;
            o.gt = a[63] ? mag_lt : (!mag_lt && !mag_eq);
        end
        return o;
    endfunction

endpackage

// ----- rtl/cpf_if.sv -----
interface cpf_in_if;
    import cpf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     row_index;
    logic [VAL_W-1:0]     left_value;
    logic [VAL_W-1:0]     right_value;
    logic                 first_filter;
    logic                 last_row;
    modport source (output valid, row_index, left_value, right_value, first_filter,
                    last_row, input ready);
    modport sink (input valid, row_index, left_value, right_value, first_filter,
                  last_row, output ready);
endinterface

interface cpf_out_if;
    import cpf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     out_row_index;
    logic                 keep;
    logic                 out_last_row;
    modport source (output valid, out_row_index, keep, out_last_row, input ready);
    modport sink (input valid, out_row_index, keep, out_last_row, output ready);
endinterface

// ----- rtl/columnar_predicate_filter.sv -----
// Pipeline: mask read (stage 1), then compare/write into the output register (stage 2).
// Throughput: one row per cycle while the output is not stalled; the keep mask is one 1-bit RAM, read and
// written once a cycle, with forwarding for back-to-back hits on one row.
// Reset (synchronous, active low) clears valids and config registers; the
// keep mask is not cleared and must be written by a first-filter pass.
module columnar_predicate_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cpf_in_if.sink                     i_in,
    cpf_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import cpf_pkg::*;

    logic [2:0]       r_op;
    logic             r_kind;
    logic             r_rlit;
    logic [VAL_W-1:0] r_lit;

    logic             mem [MAX_ROWS];
    logic             r_rd;

    // stage 1: mask read in flight
    logic             r_s1_v;
    logic [ROW_W-1:0] r_s1_row;
    logic [VAL_W-1:0] r_s1_l;
    logic [VAL_W-1:0] r_s1_r;
    logic             r_s1_first;
    logic             r_s1_last;

    // stage 2: output register
    logic             r_s2_v;
    logic [ROW_W-1:0] r_s2_row;
    logic             r_s2_keep;
    logic             r_s2_last;

    // last written row, for forwarding
    logic             r_wb_v;
    logic [ROW_W-1:0] r_wb_row;
    logic             r_wb_bit;

    logic             adv;
    logic             acc;
    logic             prior;
    logic             n_keep;
    logic             pass;
    logic             in_rng;
    t_order           ord;

    assign pready = 1'b1;
    assign adv    = !r_s2_v || o_out.ready;
    assign i_in.ready = adv;
    assign acc    = i_in.valid && adv;
    assign in_rng = ({1'b0, r_s1_row} < (ROW_W+1)'(MAX_ROWS));

    always_comb begin
        prior = 1'b0;
        if (r_s1_first) begin
            prior = 1'b1;
        end else if (in_rng) begin
            prior = (r_wb_v && r_wb_row == r_s1_row) ? r_wb_bit : r_rd;
        end
        ord = order_of(r_s1_l, r_rlit ? r_lit : r_s1_r, r_kind);
        case (r_op)
            OP_LE:   pass = ord.lt || ord.eq;
            OP_LT:   pass = ord.lt;
            OP_GE:   pass = ord.gt || ord.eq;
            OP_GT:   pass = ord.gt;
            OP_EQ:   pass = ord.eq;
            default: pass = 1'b1;
        endcase
        n_keep = prior && pass;
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            REG_COMPARE_OP: prdata = {61'd0, r_op};
            REG_VALUE_KIND: prdata = {63'd0, r_kind};
            REG_RIGHT_LIT:  prdata = {63'd0, r_rlit};
            REG_LITERAL:    prdata = r_lit;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_LE;
            r_kind <= 1'b0;
            r_rlit <= 1'b1;
            r_lit  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_COMPARE_OP: r_op   <= pwdata[2:0];
                REG_VALUE_KIND: r_kind <= pwdata[0];
                REG_RIGHT_LIT:  r_rlit <= pwdata[0];
                REG_LITERAL:    r_lit  <= pwdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_rd <= mem[i_in.row_index[ADDR_W-1:0]];
        if (adv && r_s1_v && in_rng) mem[r_s1_row[ADDR_W-1:0]] <= n_keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_wb_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= acc;
            r_s2_v <= r_s1_v;
            r_wb_v <= r_s1_v && in_rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_row   <= i_in.row_index;
            r_s1_l     <= i_in.left_value;
            r_s1_r     <= i_in.right_value;
            r_s1_first <= i_in.first_filter;
            r_s1_last  <= i_in.last_row;
            r_s2_row   <= r_s1_row;
            r_s2_keep  <= n_keep;
            r_s2_last  <= r_s1_last;
            r_wb_row   <= r_s1_row;
            r_wb_bit   <= n_keep;
        end
    end

    assign o_out.valid         = r_s2_v;
    assign o_out.out_row_index = r_s2_row;
    assign o_out.keep          = r_s2_keep;
    assign o_out.out_last_row  = r_s2_last;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !o_out.ready) |=> (r_s2_v && $stable(r_s2_keep)))
        else $error("result changed while stalled");
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");
    a_first_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_v && r_s1_first && r_op > 3'd4) |=> r_s2_keep)
        else $error("first pass with pass-all op dropped row");
endmodule
